@@ hw/rtl/kns_pkg.sv @@
package kns_pkg;

    // field widths
    localparam int KEY_BITS   = 12;
    localparam int STEP_BITS  = 32;
    localparam int NOTE_BITS  = 4;
    localparam int SAMP_BITS  = 8;

    // accumulator width, valid from 16 to 48
    localparam int PHASE_BITS = 32;
    localparam int SUM_BITS   = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

    // request kinds
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // all keys released (active low)
    localparam logic [KEY_BITS-1:0] KEYS_IDLE = '1;

    // one-cycle update strobes from the pipeline to the state holders
    typedef struct packed {
        logic scan_en;
        logic tick_en;
    } kns_ctrl_t;

    // voice state after the update of the current request
    typedef struct packed {
        logic [STEP_BITS-1:0] step;
        logic [NOTE_BITS-1:0] note;
        logic                 held;
    } kns_voice_t;

    // phase increment for each semitone, C upwards
    function automatic logic [STEP_BITS-1:0] note_step(input logic [NOTE_BITS-1:0] n);
        logic [STEP_BITS-1:0] s;
        unique case (n)
            4'd0:    s = 32'd51076057;
            4'd1:    s = 32'd54113197;
            4'd2:    s = 32'd57330935;
            4'd3:    s = 32'd60740010;
            4'd4:    s = 32'd64351799;
            4'd5:    s = 32'd68178356;
            4'd6:    s = 32'd72232452;
            4'd7:    s = 32'd76527617;
            4'd8:    s = 32'd81078186;
            4'd9:    s = 32'd85899346;
            4'd10:   s = 32'd91007187;
            4'd11:   s = 32'd96418756;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/kns_req_if.sv @@
interface kns_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [kns_pkg::KEY_BITS-1:0] keys;

    modport source (output valid, output action, output keys, input ready);
    modport sink   (input valid, input action, input keys, output ready);
endinterface

@@ hw/rtl/kns_rsp_if.sv @@
interface kns_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [kns_pkg::SAMP_BITS-1:0] sample;
    logic [kns_pkg::STEP_BITS-1:0] step_size;
    logic [kns_pkg::NOTE_BITS-1:0] note_index;
    logic                          any_pressed;

    modport source (output valid, output sample, output step_size, output note_index,
                    output any_pressed, input ready);
    modport sink   (input valid, input sample, input step_size, input note_index,
                    input any_pressed, output ready);
endinterface

@@ hw/rtl/key_to_nco_sawtooth_unit.sv @@
// channel | dir | handshake         | payload
// req     | in  | valid/ready       | action, keys
// rsp     | out | valid/ready       | sample, step_size, note_index, any_pressed
//
// one response per request, one request per cycle sustained while rsp.ready holds
// a request goes through the input register, then its update goes into the response register
// the combinational path between the registers is the key compare with lowest-key encode or one phase add
// rst_n clears the voice state, the phase and both valid flags at once
// a stalled response holds the pipe; the input register keeps taking requests while it is free
module key_to_nco_sawtooth_unit (
    input  logic   clk,
    input  logic   rst_n,
    kns_req_if.sink    req,
    kns_rsp_if.source  rsp
);
    import kns_pkg::*;

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                action_reg;
    logic [KEY_BITS-1:0] keys_reg;

    // response register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SAMP_BITS-1:0] sample_reg;
    logic [STEP_BITS-1:0] step_size_reg;
    logic [NOTE_BITS-1:0] note_reg;
    logic                 pressed_reg;

    logic                 advance;
    logic                 take;
    kns_ctrl_t            ctrl;
    kns_voice_t           voice_next;
    logic [STEP_BITS-1:0] step_now;
    logic [SAMP_BITS-1:0] sample_next;

    // the held request moves on when the response slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take = req.valid && req.ready;

    // state only moves on the cycle a request leaves the input register
    assign ctrl.scan_en = advance && (action_reg == ACT_SCAN);
    assign ctrl.tick_en = advance && (action_reg == ACT_TICK);

    kns_voice u_voice (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .keys       (keys_reg),
        .step_now   (step_now),
        .voice_next (voice_next)
    );

    // step cannot change on a tick, so the current step feeds the add
    kns_phase_acc u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .step        (step_now),
        .sample_next (sample_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= req.action;
            keys_reg   <= req.keys;
        end
        if (advance)
        begin
            sample_reg    <= sample_next;
            step_size_reg <= voice_next.step;
            note_reg      <= voice_next.note;
            pressed_reg   <= voice_next.held;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.sample      = sample_reg;
    assign rsp.step_size   = step_size_reg;
    assign rsp.note_index  = note_reg;
    assign rsp.any_pressed = pressed_reg;

endmodule

@@ hw/rtl/kns_voice.sv @@
module kns_voice (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kns_pkg::kns_ctrl_t           ctrl,
    input  logic [kns_pkg::KEY_BITS-1:0] keys,
    output logic [kns_pkg::STEP_BITS-1:0] step_now,
    output kns_pkg::kns_voice_t          voice_next
);
    import kns_pkg::*;

    logic [KEY_BITS-1:0]  prev_keys_reg;
    logic [KEY_BITS-1:0]  prev_keys_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [NOTE_BITS-1:0] note_reg;
    logic [NOTE_BITS-1:0] note_next;
    logic                 held_reg;
    logic                 held_next;
    logic [KEY_BITS-1:0]  changed;
    logic [NOTE_BITS-1:0] lowest;

    assign changed = keys ^ prev_keys_reg;

    // priority encoder, lowest changed key wins
    always_comb
    begin
        lowest = '0;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            if (changed[i])
            begin
                lowest = NOTE_BITS'(i);
            end
        end
    end

    always_comb
    begin
        prev_keys_next = prev_keys_reg;
        step_next      = step_reg;
        note_next      = note_reg;
        held_next      = held_reg;
        if (ctrl.scan_en)
        begin
            prev_keys_next = keys;
            if (changed != '0)
            begin
                note_next = lowest;
                step_next = note_step(lowest);
            end
            if (keys == KEYS_IDLE)
            begin
                held_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                held_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
            step_reg      <= '0;
            note_reg      <= '0;
            held_reg      <= 1'b0;
        end
        else
        begin
            prev_keys_reg <= prev_keys_next;
            step_reg      <= step_next;
            note_reg      <= note_next;
            held_reg      <= held_next;
        end
    end

    assign step_now        = step_reg;
    assign voice_next.step = step_next;
    assign voice_next.note = note_next;
    assign voice_next.held = held_next;

endmodule

@@ hw/rtl/kns_phase_acc.sv @@
module kns_phase_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kns_pkg::kns_ctrl_t            ctrl,
    input  logic [kns_pkg::STEP_BITS-1:0] step,
    output logic [kns_pkg::SAMP_BITS-1:0] sample_next
);
    import kns_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [SUM_BITS-1:0]   sum;

    // wraps modulo the accumulator width
    assign sum = SUM_BITS'(phase_reg) + SUM_BITS'(step);

    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.tick_en)
        begin
            phase_next = sum[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign sample_next = phase_next[PHASE_BITS-1 -: SAMP_BITS];

endmodule
